### design/srrt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted ring record table package
// Shared types, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package srrt_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int TDATA_W       = 120;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_RMKEY  = 3'd1;
    localparam logic [2:0] OP_RMPOS  = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_FIND   = 3'd4;

    typedef struct packed {
        logic [7:0]  group;
        logic [31:0] finish;
        logic [31:0] split;
        logic [31:0] start;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef struct packed {
        logic       hist;
        logic [3:0] pos;
        logic       wb;
        rec_t       rec;
        logic [2:0] op;
    } in_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_START,
        CMD_RD_IDX,
        CMD_IDX_INC,
        CMD_WR_IN_IDX,
        CMD_SET_TGT,
        CMD_IDX_CLR,
        CMD_DROP,
        CMD_K_INIT,
        CMD_RD_KM1,
        CMD_WR_K_DEC,
        CMD_TGT_POS,
        CMD_RD_TGT,
        CMD_HOLD,
        CMD_ADD_FIN,
        CMD_REM_FIN,
        CMD_RD_POS,
        CMD_RES_READ,
        CMD_FOUND
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       wb;
        logic       key_zero;
        logic       key_eq;
        logic       key_ge;
        logic       idx_lt_lim;
        logic       idx_lt_cnt;
        logic       idx_gt_tgt;
        logic       idx_nz;
        logic       full;
        logic       drop;
        logic       pos_lt_cnt;
    } dp_stat_t;

endpackage

`default_nettype wire

### design/srrt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### design/srrt_datapath.sv
// ----------------------------------------------------------------------------
// Sorted ring record table datapath
// Record store, ring pointers, walk index and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module srrt_datapath #(
    parameter int TABLE_DEPTH = srrt_pkg::DEPTH_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire srrt_pkg::dp_cmd_t            cmd,
    output srrt_pkg::dp_stat_t                stat,
    input  wire logic [srrt_pkg::TDATA_W-1:0] s_tdata,
    output logic      [srrt_pkg::TDATA_W-1:0] m_tdata,
    input  wire logic                         cfg_valid,
    input  wire logic                         cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW:0]   DEPTH_W = (CW + 1)'(TABLE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

    function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] rel);
        logic [CW:0] s;
        s = (CW + 1)'(base) + (CW + 1)'(rel);
        if (s >= DEPTH_W)
        begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] pos_mod(logic [3:0] p);
        logic [7:0] v;
        v = 8'(p);
        for (int i = 0; i < 8; i++)
        begin
            if (v >= 8'(TABLE_DEPTH))
            begin
                v = v - 8'(TABLE_DEPTH);
            end
        end
        return v[AW-1:0];
    endfunction

    srrt_pkg::in_t    in_reg, in_next;
    srrt_pkg::rec_t   hold_reg, hold_next;
    srrt_pkg::rec_t   res_reg, res_next;
    srrt_pkg::rec_t   rd_rec;
    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    pmod_reg, pmod_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    tgt_reg, tgt_next;
    logic             acc_reg, acc_next;
    logic [3:0]       fpos_reg, fpos_next;
    logic             drop_reg;
    logic [TABLE_DEPTH-1:0] vld_reg, vld_next;
    logic             vld_q_reg, vld_q_next;
    logic             we, re;
    logic [AW-1:0]    waddr, raddr;
    srrt_pkg::rec_t   wdata;
    logic [srrt_pkg::REC_W-1:0] ram_q;
    logic [CW-1:0]    lim;
    logic [AW-1:0]    head_inc;

    srrt_ram #(
        .WIDTH (srrt_pkg::REC_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (ram_q)
    );

    assign rd_rec   = vld_q_reg ? srrt_pkg::rec_t'(ram_q) : '0;
    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
    assign lim      = (in_reg.hist && in_reg.op == srrt_pkg::OP_FIND) ? DEPTH_C : cnt_reg;

    always_comb
    begin
        stat.op         = in_reg.op;
        stat.wb         = in_reg.wb;
        stat.key_zero   = (in_reg.rec.start == 32'd0);
        stat.key_eq     = (rd_rec.start == in_reg.rec.start);
        stat.key_ge     = (rd_rec.start >= in_reg.rec.start);
        stat.idx_lt_lim = (idx_reg < lim);
        stat.idx_lt_cnt = (idx_reg < cnt_reg);
        stat.idx_gt_tgt = (idx_reg > tgt_reg);
        stat.idx_nz     = (idx_reg != '0);
        stat.full       = (cnt_reg >= DEPTH_C);
        stat.drop       = drop_reg;
        stat.pos_lt_cnt = ((CW + 4)'(in_reg.pos) < (CW + 4)'(cnt_reg));
    end

    always_comb
    begin
        in_next   = in_reg;
        hold_next = hold_reg;
        res_next  = res_reg;
        head_next = head_reg;
        pmod_next = pmod_reg;
        cnt_next  = cnt_reg;
        idx_next  = idx_reg;
        tgt_next  = tgt_reg;
        acc_next  = acc_reg;
        fpos_next = fpos_reg;
        we        = 1'b0;
        re        = 1'b0;
        waddr     = wrap_add(head_reg, idx_reg);
        raddr     = wrap_add(head_reg, idx_reg);
        wdata     = in_reg.rec;
        unique case (cmd)
            srrt_pkg::CMD_START:
            begin
                in_next   = s_tdata[$bits(srrt_pkg::in_t)-1:0];
                pmod_next = pos_mod(s_tdata[111:108]);
                idx_next  = '0;
                acc_next  = 1'b0;
                fpos_next = 4'd0;
                res_next  = '0;
            end
            srrt_pkg::CMD_RD_IDX:
            begin
                re = 1'b1;
            end
            srrt_pkg::CMD_IDX_INC:
            begin
                idx_next = idx_reg + 1'b1;
            end
            srrt_pkg::CMD_WR_IN_IDX:
            begin
                we = 1'b1;
            end
            srrt_pkg::CMD_SET_TGT:
            begin
                tgt_next = idx_reg;
            end
            srrt_pkg::CMD_IDX_CLR:
            begin
                idx_next = '0;
            end
            srrt_pkg::CMD_DROP:
            begin
                head_next = head_inc;
                cnt_next  = cnt_reg - 1'b1;
                idx_next  = '0;
            end
            srrt_pkg::CMD_K_INIT:
            begin
                idx_next = cnt_reg;
            end
            srrt_pkg::CMD_RD_KM1:
            begin
                re    = 1'b1;
                raddr = wrap_add(head_reg, idx_reg - 1'b1);
            end
            srrt_pkg::CMD_WR_K_DEC:
            begin
                we       = 1'b1;
                wdata    = rd_rec;
                idx_next = idx_reg - 1'b1;
            end
            srrt_pkg::CMD_TGT_POS:
            begin
                tgt_next = CW'(in_reg.pos);
            end
            srrt_pkg::CMD_RD_TGT:
            begin
                re    = 1'b1;
                raddr = wrap_add(head_reg, tgt_reg);
            end
            srrt_pkg::CMD_HOLD:
            begin
                hold_next = (in_reg.wb && in_reg.op == srrt_pkg::OP_RMKEY) ? in_reg.rec : rd_rec;
                idx_next  = tgt_reg;
            end
            srrt_pkg::CMD_ADD_FIN:
            begin
                we       = 1'b1;
                waddr    = wrap_add(head_reg, tgt_reg);
                cnt_next = cnt_reg + 1'b1;
                acc_next = 1'b1;
            end
            srrt_pkg::CMD_REM_FIN:
            begin
                we        = 1'b1;
                waddr     = head_reg;
                wdata     = hold_reg;
                head_next = head_inc;
                cnt_next  = cnt_reg - 1'b1;
                acc_next  = 1'b1;
            end
            srrt_pkg::CMD_RD_POS:
            begin
                re    = 1'b1;
                raddr = wrap_add(head_reg, CW'(pmod_reg));
            end
            srrt_pkg::CMD_RES_READ:
            begin
                res_next = rd_rec;
                acc_next = stat.pos_lt_cnt;
            end
            srrt_pkg::CMD_FOUND:
            begin
                acc_next  = 1'b1;
                fpos_next = 4'(idx_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (we)
        begin
            vld_next[waddr] = 1'b1;
        end
        vld_q_next = re ? vld_reg[raddr] : vld_q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            tgt_reg   <= '0;
            drop_reg  <= 1'b0;
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            tgt_reg   <= tgt_next;
            vld_reg   <= vld_next;
            vld_q_reg <= vld_q_next;
            if (cfg_valid)
            begin
                drop_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg   <= in_next;
        hold_reg <= hold_next;
        res_reg  <= res_next;
        pmod_reg <= pmod_next;
        acc_reg  <= acc_next;
        fpos_reg <= fpos_next;
    end

    assign m_tdata = {6'd0, 5'(cnt_reg), res_reg, fpos_reg, acc_reg};

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_C)
        else $error("entry count above table depth");

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= LAST_SLOT)
        else $error("head index outside the ring");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(we && re))
        else $error("store read and written in the same cycle");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == srrt_pkg::CMD_ADD_FIN |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("add did not grow the table by one");

endmodule

`default_nettype wire

### design/srrt_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted ring record table controller
// Sequences scan, shift and write steps of each operation on the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module srrt_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    input  wire srrt_pkg::dp_stat_t stat,
    output srrt_pkg::dp_cmd_t       cmd
);

    typedef enum logic [17:0] {
        S_IDLE     = 18'h00001,
        S_DISP     = 18'h00002,
        S_SC_RD    = 18'h00004,
        S_SC_CMP   = 18'h00008,
        S_ADD_CHK  = 18'h00010,
        S_INS_RD   = 18'h00020,
        S_INS_CMP  = 18'h00040,
        S_SH_INIT  = 18'h00080,
        S_SH_RD    = 18'h00100,
        S_SH_WR    = 18'h00200,
        S_ADD_WR   = 18'h00400,
        S_REM_RD   = 18'h00800,
        S_REM_HOLD = 18'h01000,
        S_RSH_RD   = 18'h02000,
        S_RSH_WR   = 18'h04000,
        S_REM_WR   = 18'h08000,
        S_RD_OUT   = 18'h10000,
        S_OUT      = 18'h20000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd        = srrt_pkg::CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd        = srrt_pkg::CMD_START;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (stat.op) inside
                    srrt_pkg::OP_ADD:
                    begin
                        state_next = stat.key_zero ? S_OUT : S_SC_RD;
                    end
                    srrt_pkg::OP_RMKEY, srrt_pkg::OP_FIND:
                    begin
                        state_next = S_SC_RD;
                    end
                    srrt_pkg::OP_RMPOS:
                    begin
                        if (stat.pos_lt_cnt)
                        begin
                            cmd        = srrt_pkg::CMD_TGT_POS;
                            state_next = S_REM_RD;
                        end
                        else
                        begin
                            state_next = S_OUT;
                        end
                    end
                    srrt_pkg::OP_READ:
                    begin
                        cmd        = srrt_pkg::CMD_RD_POS;
                        state_next = S_RD_OUT;
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_SC_RD:
            begin
                if (stat.idx_lt_lim)
                begin
                    cmd        = srrt_pkg::CMD_RD_IDX;
                    state_next = S_SC_CMP;
                end
                else
                begin
                    state_next = (stat.op == srrt_pkg::OP_ADD) ? S_ADD_CHK : S_OUT;
                end
            end
            S_SC_CMP:
            begin
                if (stat.key_eq)
                begin
                    if (stat.op == srrt_pkg::OP_ADD)
                    begin
                        cmd        = stat.wb ? srrt_pkg::CMD_WR_IN_IDX : srrt_pkg::CMD_NONE;
                        state_next = S_OUT;
                    end
                    else if (stat.op == srrt_pkg::OP_RMKEY)
                    begin
                        cmd        = srrt_pkg::CMD_SET_TGT;
                        state_next = S_REM_RD;
                    end
                    else
                    begin
                        cmd        = srrt_pkg::CMD_FOUND;
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    cmd        = srrt_pkg::CMD_IDX_INC;
                    state_next = S_SC_RD;
                end
            end
            S_ADD_CHK:
            begin
                if (stat.full && !stat.drop)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd        = stat.full ? srrt_pkg::CMD_DROP : srrt_pkg::CMD_IDX_CLR;
                    state_next = S_INS_RD;
                end
            end
            S_INS_RD:
            begin
                if (stat.idx_lt_cnt)
                begin
                    cmd        = srrt_pkg::CMD_RD_IDX;
                    state_next = S_INS_CMP;
                end
                else
                begin
                    cmd        = srrt_pkg::CMD_SET_TGT;
                    state_next = S_SH_INIT;
                end
            end
            S_INS_CMP:
            begin
                if (stat.key_ge)
                begin
                    cmd        = srrt_pkg::CMD_SET_TGT;
                    state_next = S_SH_INIT;
                end
                else
                begin
                    cmd        = srrt_pkg::CMD_IDX_INC;
                    state_next = S_INS_RD;
                end
            end
            S_SH_INIT:
            begin
                cmd        = srrt_pkg::CMD_K_INIT;
                state_next = S_SH_RD;
            end
            S_SH_RD:
            begin
                if (stat.idx_gt_tgt)
                begin
                    cmd        = srrt_pkg::CMD_RD_KM1;
                    state_next = S_SH_WR;
                end
                else
                begin
                    state_next = S_ADD_WR;
                end
            end
            S_SH_WR:
            begin
                cmd        = srrt_pkg::CMD_WR_K_DEC;
                state_next = S_SH_RD;
            end
            S_ADD_WR:
            begin
                cmd        = srrt_pkg::CMD_ADD_FIN;
                state_next = S_OUT;
            end
            S_REM_RD:
            begin
                cmd        = srrt_pkg::CMD_RD_TGT;
                state_next = S_REM_HOLD;
            end
            S_REM_HOLD:
            begin
                cmd        = srrt_pkg::CMD_HOLD;
                state_next = S_RSH_RD;
            end
            S_RSH_RD:
            begin
                if (stat.idx_nz)
                begin
                    cmd        = srrt_pkg::CMD_RD_KM1;
                    state_next = S_RSH_WR;
                end
                else
                begin
                    state_next = S_REM_WR;
                end
            end
            S_RSH_WR:
            begin
                cmd        = srrt_pkg::CMD_WR_K_DEC;
                state_next = S_RSH_RD;
            end
            S_REM_WR:
            begin
                cmd        = srrt_pkg::CMD_REM_FIN;
                state_next = S_OUT;
            end
            S_RD_OUT:
            begin
                cmd        = srrt_pkg::CMD_RES_READ;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("controller stayed idle after a beat was taken");

    a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |=> s_tready)
        else $error("controller did not return to idle after the result beat");

endmodule

`default_nettype wire

### design/sorted_ring_record_table_core.sv
// ----------------------------------------------------------------------------
// Sorted ring record table core
// A ring of records kept sorted by start key, with add, remove, read and find.
// ----------------------------------------------------------------------------
// One item is handled at a time; the next beat is taken the cycle after the
// result beat is taken. Find, remove and add walk and shift one entry at a
// time through the record store, which has one read and one write port.
// Reset clears pointers and per-entry valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_ring_record_table_core #(
    parameter int TABLE_DEPTH = srrt_pkg::DEPTH_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // operation, record_start, record_split, record_finish, record_group,
    // write_back, position, include_history
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [srrt_pkg::TDATA_W-1:0] s_tdata,
    // accepted, found_position, out_start, out_split, out_finish, out_group,
    // active_count
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [srrt_pkg::TDATA_W-1:0] m_tdata,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic                         cfg_data
);

    srrt_pkg::dp_cmd_t  cmd;
    srrt_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    srrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    srrt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire
